// ----- design/linear_probe_session_table_defines.svh -----
// Assertion macros used by the checked module of the session table.
`ifndef LINEAR_PROBE_SESSION_TABLE_DEFINES_SVH
`define LINEAR_PROBE_SESSION_TABLE_DEFINES_SVH

// Checked at every clock edge outside reset.
`define LPST_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every clock edge, reset cycles included.
`define LPST_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- design/lpst_pkg.sv -----
package lpst_pkg;

    localparam int SLOTS = 64;
    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int ID_W = 32;
    localparam int CONN_W = 16;

    localparam int TS_W = 7;
    localparam logic [TS_W-1:0] TABLE_SIZE_RST = 7'd64;
    localparam int SLOT_OUT_W = 6;
    localparam int LIVE_W = 7;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_TABLE_SIZE = 1'b0;

    localparam logic [1:0] REQ_ADD = 2'd0;
    localparam logic [1:0] REQ_LOOKUP = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MOD,
        S_PROBE,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [ID_W-1:0]   client_id;
        logic [CONN_W-1:0] conn_handle;
    } t_req;

    typedef struct packed {
        logic [1:0]            status;
        logic [SLOT_OUT_W-1:0] slot_index;
        logic [ID_W-1:0]       session_id;
        logic [CONN_W-1:0]     slot_handle;
        logic [LIVE_W-1:0]     live_count;
    } t_rsp;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [CONN_W-1:0] conn;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_entry           wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } t_ram_cmd;

    typedef struct packed {
        logic             done;
        logic [IDX_W-1:0] rem;
    } t_mod_rsp;

endpackage

// ----- design/linear_probe_session_table.sv -----
// Session table of 64 slots with linear probing, one transaction in flight at a time.
// A request is taken only when the table is idle; the home slot is found by a bit-serial
// modulo unit, after which the probe reads one slot entry per cycle from the entry
// memory, probing 1 to table_size slots. A request of unknown type skips the modulo and
// the probe. A finished response waits in an output register and does not hold up the
// next request until that request is itself ready to answer. Occupancy bits sit in
// flip-flops and are cleared by reset at once, so no clearing pass is needed. table_size
// is written over the APB port at address 0; the user must write it only while no
// request is in progress, which the block itself does not enforce. 0 acts as 1 and
// values above 64 act as 64.
module linear_probe_session_table
    import lpst_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  i_req_valid,
    output logic                  o_req_ready,
    input  t_req                  i_req,
    output logic                  o_rsp_valid,
    input  logic                  i_rsp_ready,
    output t_rsp                  o_rsp
);

    logic [TS_W-1:0]  r_table_size;
    logic [CNT_W-1:0] size_act;
    logic             mod_start;
    logic [ID_W-1:0]  mod_dividend;
    t_mod_rsp         mod_rsp;
    t_ram_cmd         ram_cmd;
    t_entry           ram_rdata;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= TABLE_SIZE_RST;
        end else if (psel && penable && pwrite && (paddr[2] == REG_TABLE_SIZE)) begin
            r_table_size <= pwdata[TS_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_TABLE_SIZE) ? APB_DATA_W'(r_table_size) : '0;

    always_comb begin
        if (r_table_size == '0) begin
            size_act = CNT_W'(1);
        end else if (32'(r_table_size) > 32'(SLOTS)) begin
            size_act = CNT_W'(SLOTS);
        end else begin
            size_act = CNT_W'(r_table_size);
        end
    end

    lpst_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (mod_dividend),
        .i_divisor  (size_act),
        .o_mod      (mod_rsp)
    );

    lpst_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ram_cmd.we),
        .i_waddr (ram_cmd.waddr),
        .i_wdata (ram_cmd.wdata),
        .i_re    (ram_cmd.re),
        .i_raddr (ram_cmd.raddr),
        .o_rdata (ram_rdata)
    );

    lpst_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_size         (size_act),
        .i_req_valid    (i_req_valid),
        .o_req_ready    (o_req_ready),
        .i_req          (i_req),
        .o_rsp_valid    (o_rsp_valid),
        .i_rsp_ready    (i_rsp_ready),
        .o_rsp          (o_rsp),
        .o_mod_start    (mod_start),
        .o_mod_dividend (mod_dividend),
        .i_mod          (mod_rsp),
        .o_ram          (ram_cmd),
        .i_ram_rdata    (ram_rdata)
    );

endmodule

// ----- design/lpst_ram.sv -----
module lpst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/lpst_mod.sv -----
module lpst_mod
    import lpst_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [ID_W-1:0]  i_dividend,
    input  logic [CNT_W-1:0] i_divisor,
    output t_mod_rsp         o_mod
);

    localparam int STEP_W = $clog2(ID_W);
    localparam int TRY_W = IDX_W + 1;
    localparam int CMP_W = (TRY_W > CNT_W) ? TRY_W : CNT_W;

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [ID_W-1:0]   r_dvd;
    logic [IDX_W-1:0]  r_rem;

    logic [CMP_W-1:0] trial;
    logic [CMP_W-1:0] div_ext;
    logic [CMP_W-1:0] diff;
    logic [IDX_W-1:0] n_rem;

    // Restoring division, one dividend bit per cycle; only the remainder is kept.
    always_comb begin
        trial = CMP_W'({r_rem, r_dvd[ID_W-1]});
        div_ext = CMP_W'(i_divisor);
        diff = trial - div_ext;
        n_rem = (trial >= div_ext) ? IDX_W'(diff) : IDX_W'(trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == STEP_W'(ID_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[ID_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_mod.done = r_done;
    assign o_mod.rem = r_rem;

endmodule

// ----- design/lpst_ctrl.sv -----
`include "linear_probe_session_table_defines.svh"

module lpst_ctrl
    import lpst_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CNT_W-1:0] i_size,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    input  t_req             i_req,
    output logic             o_rsp_valid,
    input  logic             i_rsp_ready,
    output t_rsp             o_rsp,
    output logic             o_mod_start,
    output logic [ID_W-1:0]  o_mod_dividend,
    input  t_mod_rsp         i_mod,
    output t_ram_cmd         o_ram,
    input  t_entry           i_ram_rdata
);

    t_state r_state;
    t_state n_state;

    t_req              r_req;
    logic [ID_W-1:0]   r_key;
    logic [IDX_W-1:0]  r_at;
    logic [CNT_W-1:0]  r_n;
    logic              r_chk_pend;
    logic              r_chk_occ;
    logic [IDX_W-1:0]  r_chk_at;
    logic              r_hit;
    logic [IDX_W-1:0]  r_pos;
    logic [CONN_W-1:0] r_handle;
    logic [SLOTS-1:0]  r_valid;
    logic [CNT_W-1:0]  r_count;
    logic [ID_W-1:0]   r_next_id;
    logic              r_rsp_valid;
    t_rsp              r_rsp;

    logic              req_fire;
    logic              req_known;
    logic              is_add;
    logic              id_match;
    logic              chk_stop;
    logic              chk_hit;
    logic              issue;
    logic              probe_done;
    logic              out_free;
    logic              do_add;
    logic              do_remove;
    logic [CNT_W-1:0]  at_inc;
    logic [IDX_W-1:0]  at_next;
    logic [CNT_W-1:0]  n_count;
    logic [1:0]        rsp_status;

    assign req_fire = i_req_valid && o_req_ready;
    assign req_known = (i_req.req_type == REQ_ADD) || (i_req.req_type == REQ_LOOKUP) ||
                       (i_req.req_type == REQ_REMOVE);
    assign is_add = (r_req.req_type == REQ_ADD);
    assign id_match = (i_ram_rdata.id == r_key);

    // The check stage looks at the slot read in the previous cycle, so probes
    // are judged strictly in chain order while the next read is already out.
    always_comb begin
        if (is_add) begin
            chk_stop = r_chk_pend && !r_chk_occ;
            chk_hit = r_chk_pend && !r_chk_occ;
        end else begin
            chk_stop = r_chk_pend && (!r_chk_occ || id_match);
            chk_hit = r_chk_pend && r_chk_occ && id_match;
        end
        issue = (r_state == S_PROBE) && !chk_stop && (r_n < i_size);
        probe_done = chk_stop || (!r_chk_pend && (r_n == i_size));
        at_inc = CNT_W'(r_at) + 1'b1;
        at_next = (at_inc >= i_size) ? '0 : IDX_W'(at_inc);
    end

    assign out_free = !r_rsp_valid || i_rsp_ready;
    assign do_add = (r_state == S_FINISH) && out_free && is_add && r_hit;
    assign do_remove = (r_state == S_FINISH) && out_free && r_hit &&
                       (r_req.req_type == REQ_REMOVE);

    always_comb begin
        n_count = r_count;
        if (do_add) begin
            n_count = r_count + 1'b1;
        end else if (do_remove && (r_count != '0)) begin
            n_count = r_count - 1'b1;
        end
        if (r_hit) begin
            rsp_status = ST_OK;
        end else if (is_add) begin
            rsp_status = ST_FULL;
        end else begin
            rsp_status = ST_NOT_FOUND;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (req_fire) begin
                    n_state = req_known ? S_MOD : S_FINISH;
                end
            end
            S_MOD: begin
                if (i_mod.done) begin
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                if (probe_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs to the handshake, the modulo unit and the entry memory.
    always_comb begin
        o_req_ready = 1'b0;
        o_mod_start = 1'b0;
        o_mod_dividend = (i_req.req_type == REQ_ADD) ? r_next_id : i_req.client_id;
        o_ram.we = do_add;
        o_ram.waddr = r_pos;
        o_ram.wdata.id = r_key;
        o_ram.wdata.conn = r_req.conn_handle;
        o_ram.re = issue;
        o_ram.raddr = r_at;
        case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                o_mod_start = req_fire && req_known;
            end
            S_MOD: ;
            S_PROBE: ;
            S_FINISH: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_count     <= '0;
            r_next_id   <= ID_W'(1);
            r_rsp_valid <= 1'b0;
            r_chk_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_MOD) begin
                r_chk_pend <= 1'b0;
            end else if (r_state == S_PROBE) begin
                r_chk_pend <= issue;
            end
            if (do_add) begin
                r_valid[r_pos] <= 1'b1;
                r_next_id <= r_next_id + 1'b1;
            end else if (do_remove) begin
                r_valid[r_pos] <= 1'b0;
            end
            r_count <= n_count;
            if ((r_state == S_FINISH) && out_free) begin
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_req <= i_req;
            r_key <= o_mod_dividend;
            r_hit <= 1'b0;
        end
        if ((r_state == S_MOD) && i_mod.done) begin
            r_at <= i_mod.rem;
            r_n  <= '0;
        end
        if (issue) begin
            r_chk_at  <= r_at;
            r_chk_occ <= r_valid[r_at];
            r_at      <= at_next;
            r_n       <= r_n + 1'b1;
        end
        if ((r_state == S_PROBE) && probe_done) begin
            r_hit    <= chk_hit;
            r_pos    <= r_chk_at;
            r_handle <= i_ram_rdata.conn;
        end
        if ((r_state == S_FINISH) && out_free) begin
            r_rsp.status      <= rsp_status;
            r_rsp.slot_index  <= r_hit ? SLOT_OUT_W'(r_pos) : '0;
            r_rsp.session_id  <= r_key;
            r_rsp.slot_handle <= r_hit ? (is_add ? r_req.conn_handle : r_handle) : '0;
            r_rsp.live_count  <= LIVE_W'(n_count);
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp = r_rsp;

    `LPST_ASSERT(a_count_matches_valid, $countones(r_valid) == 32'(r_count), "live count differs from occupied slots")
    `LPST_ASSERT(a_probe_bounded, (r_state == S_PROBE) |-> (r_n <= i_size), "probe ran past the active size")
    `LPST_ASSERT(a_home_in_range, i_mod.done |-> (CNT_W'(i_mod.rem) < i_size), "home slot outside the active size")
    `LPST_ASSERT(a_rsp_from_finish, $rose(r_rsp_valid) |-> ($past(r_state) == S_FINISH), "response raised outside finish")
    `LPST_ASSERT_RST(a_reset_clears, !i_rst_n |=> ((r_count == '0) && !r_rsp_valid), "reset left state behind")

endmodule
